/* rtl/otc_pkg.sv */
package otc_pkg;

    // phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_COARSE = 2'd1;
    localparam logic [1:0] PH_FINE   = 2'd2;

    // input operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_DEFAULT_TRIM = 3'd0;
    localparam logic [2:0] REG_REF_PERIOD   = 3'd1;
    localparam logic [2:0] REG_KEEP_LIMIT   = 3'd2;
    localparam logic [2:0] REG_NEAR_LIMIT   = 3'd3;
    localparam logic [2:0] REG_RUN_NEEDED   = 3'd4;

    // configuration reset values
    localparam logic [7:0]  RST_DEFAULT_TRIM = 8'd128;
    localparam logic [15:0] RST_REF_PERIOD   = 16'd32768;
    localparam logic [15:0] RST_KEEP_LIMIT   = 16'd200;
    localparam logic [15:0] RST_NEAR_LIMIT   = 16'd1000;
    localparam logic [2:0]  RST_RUN_NEEDED   = 3'd5;

    // sweep constants
    localparam logic [7:0] SWEEP_START    = 8'hEF;
    localparam logic [7:0] SWEEP_FLOOR    = 8'h0F;
    localparam logic [7:0] FINE_LOW_OFS   = 8'd10;
    localparam logic [4:0] FINE_LAST_STEP = 5'd30;
    localparam logic [3:0] COARSE_WARM    = 4'd1;
    localparam logic [3:0] COARSE_NEED    = 4'd2;
    localparam logic [3:0] FINE_WARM      = 4'd5;
    localparam logic [3:0] FINE_NEED      = 4'd15;
    localparam logic [2:0] NEAR_MAX       = 3'd7;

    // error arithmetic
    localparam logic signed [19:0] TOTAL_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] TOTAL_MIN = 20'sh80000;
    localparam logic [16:0]        ERR_MAX   = 17'd65535;
    // ceil(2^23 / 10), exact quotient for magnitudes below 2^22
    localparam logic [19:0]        RECIP_TEN = 20'd838861;
    localparam int                 RECIP_SHIFT = 23;

    typedef struct packed {
        logic [7:0]  default_trim;
        logic [15:0] ref_period;
        logic [15:0] keep_limit;
        logic [15:0] near_limit;
        logic [2:0]  run_needed;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [15:0] period_count;
    } t_item;

endpackage

/* rtl/otc_cfg.sv */
module otc_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output otc_pkg::t_cfg      o_cfg
);

    otc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_trim <= otc_pkg::RST_DEFAULT_TRIM;
            r_cfg.ref_period   <= otc_pkg::RST_REF_PERIOD;
            r_cfg.keep_limit   <= otc_pkg::RST_KEEP_LIMIT;
            r_cfg.near_limit   <= otc_pkg::RST_NEAR_LIMIT;
            r_cfg.run_needed   <= otc_pkg::RST_RUN_NEEDED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                otc_pkg::REG_DEFAULT_TRIM: r_cfg.default_trim <= i_cfg_data[7:0];
                otc_pkg::REG_REF_PERIOD:   r_cfg.ref_period   <= i_cfg_data;
                otc_pkg::REG_KEEP_LIMIT:   r_cfg.keep_limit   <= i_cfg_data;
                otc_pkg::REG_NEAR_LIMIT:   r_cfg.near_limit   <= i_cfg_data;
                otc_pkg::REG_RUN_NEEDED:   r_cfg.run_needed   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/otc_in_reg.sv */
module otc_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_op,
    input  logic [15:0]        i_period_count,
    output logic               o_stall,
    input  logic               i_take,
    output logic               o_vld,
    output otc_pkg::t_item     o_item
);

    logic           r_vld;
    otc_pkg::t_item r_item;
    logic           w_load;

    // register frees up in the same cycle the core consumes it
    assign o_stall = r_vld && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.op           <= i_op;
            r_item.period_count <= i_period_count;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

/* rtl/otc_core.sv */
module otc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  otc_pkg::t_cfg       i_cfg,
    input  logic                i_vld,
    input  otc_pkg::t_item      i_item,
    output logic                o_take,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_stage,
    output logic [7:0]          o_trim_used,
    output logic signed [16:0]  o_avg_error,
    output logic [7:0]          o_best_trim,
    output logic                o_last
);

    logic [1:0]         r_phase, n_phase;
    logic [7:0]         r_trim, n_trim;
    logic [7:0]         r_work, n_work;
    logic [2:0]         r_near, n_near;
    logic               r_armed, n_armed;
    logic [3:0]         r_edge, n_edge;
    logic signed [19:0] r_total, n_total;
    logic [4:0]         r_fstep, n_fstep;

    logic               r_out_vld;
    logic               r_stage, r_last;
    logic [7:0]         r_trim_used, r_best;
    logic signed [16:0] r_avg;

    logic               w_res, w_last;
    logic signed [16:0] w_err;

    logic               w_fine;
    logic signed [17:0] w_diff;
    logic signed [20:0] w_sum;
    logic signed [19:0] w_sat;
    logic [19:0]        w_mag;
    logic [39:0]        w_prod;
    logic [16:0]        w_quo;
    logic [16:0]        w_coarse_err;
    logic signed [16:0] w_fine_err;
    logic [4:0]         w_fstep_inc;

    assign o_take = i_vld && (!r_out_vld || !i_stall);

    assign w_fine = (r_phase == otc_pkg::PH_FINE);
    assign w_diff = $signed({2'b00, i_item.period_count}) - $signed({2'b00, i_cfg.ref_period});
    assign w_sum  = 21'(r_total) + 21'(w_diff);
    // saturate when the two top bits disagree
    assign w_sat  = (w_sum[20] != w_sum[19]) ?
                    (w_sum[20] ? otc_pkg::TOTAL_MIN : otc_pkg::TOTAL_MAX) : w_sum[19:0];

    assign w_fstep_inc = r_fstep + 5'd1;

    always_comb begin
        n_phase = r_phase;
        n_trim  = r_trim;
        n_work  = r_work;
        n_near  = r_near;
        n_armed = r_armed;
        n_edge  = r_edge;
        n_total = r_total;
        n_fstep = r_fstep;
        w_res   = 1'b0;
        w_last  = 1'b0;
        w_err   = '0;
        w_mag   = '0;
        w_prod  = '0;
        w_quo   = '0;
        w_coarse_err = '0;
        w_fine_err   = '0;

        if (i_item.op == otc_pkg::OP_START) begin
            n_phase = otc_pkg::PH_COARSE;
            n_work  = i_cfg.default_trim;
            n_trim  = otc_pkg::SWEEP_START;
            n_near  = '0;
            n_fstep = '0;
            n_armed = 1'b0;
            n_edge  = '0;
            n_total = '0;
        end else if (r_phase == otc_pkg::PH_COARSE || r_phase == otc_pkg::PH_FINE) begin
            if (!r_armed) begin
                n_armed = 1'b1;
            end else begin
                if (r_edge >= (w_fine ? otc_pkg::FINE_WARM : otc_pkg::COARSE_WARM)) begin
                    n_total = w_sat;
                end
                n_edge = r_edge + 4'd1;
                if (n_edge >= (w_fine ? otc_pkg::FINE_NEED : otc_pkg::COARSE_NEED)) begin
                    w_res = 1'b1;
                    w_mag = n_total[19] ? 20'(-n_total) : 20'(n_total);
                    // divide by ten through the reciprocal, truncating toward zero
                    w_prod = 40'(w_mag) * 40'(otc_pkg::RECIP_TEN);
                    w_quo  = w_prod[otc_pkg::RECIP_SHIFT +: 17];
                    w_fine_err   = n_total[19] ? -$signed(w_quo) : $signed(w_quo);
                    w_coarse_err = (w_mag > 20'(otc_pkg::ERR_MAX)) ? otc_pkg::ERR_MAX
                                                                   : w_mag[16:0];
                    n_armed = 1'b0;
                    n_edge  = '0;
                    n_total = '0;
                    if (!w_fine) begin
                        w_err = $signed(w_coarse_err);
                        if (w_coarse_err < {1'b0, i_cfg.keep_limit}) begin
                            n_work = r_trim;
                        end
                        if (w_coarse_err < {1'b0, i_cfg.near_limit}) begin
                            if (r_near < otc_pkg::NEAR_MAX) begin
                                n_near = r_near + 3'd1;
                            end
                        end else begin
                            n_near = '0;
                        end
                        if (n_near == i_cfg.run_needed || r_trim < otc_pkg::SWEEP_FLOOR) begin
                            n_phase = otc_pkg::PH_FINE;
                            n_fstep = '0;
                            n_trim  = n_work - otc_pkg::FINE_LOW_OFS;
                        end else begin
                            n_trim = r_trim - 8'd1;
                        end
                    end else begin
                        w_err = w_fine_err;
                        if (r_fstep >= otc_pkg::FINE_LAST_STEP) begin
                            w_last  = 1'b1;
                            n_phase = otc_pkg::PH_IDLE;
                            n_fstep = '0;
                        end else begin
                            n_fstep = w_fstep_inc;
                            n_trim  = r_work + {3'b000, w_fstep_inc} - otc_pkg::FINE_LOW_OFS;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= otc_pkg::PH_IDLE;
            r_trim  <= '0;
            r_work  <= '0;
            r_near  <= '0;
            r_armed <= 1'b0;
            r_edge  <= '0;
            r_total <= '0;
            r_fstep <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_trim  <= n_trim;
            r_work  <= n_work;
            r_near  <= n_near;
            r_armed <= n_armed;
            r_edge  <= n_edge;
            r_total <= n_total;
            r_fstep <= n_fstep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_take && w_res) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_res) begin
            r_stage     <= w_fine;
            r_trim_used <= r_trim;
            r_avg       <= w_err;
            r_best      <= n_work;
            r_last      <= w_last;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_stage     = r_stage;
    assign o_trim_used = r_trim_used;
    assign o_avg_error = r_avg;
    assign o_best_trim = r_best;
    assign o_last      = r_last;

    a_last_only_fine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_last |-> r_stage)
        else $error("last flag on a coarse result");

    a_coarse_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_stage |-> !r_avg[16])
        else $error("negative coarse error");

    a_unarmed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_edge == 4'd0 && r_total == 20'sd0))
        else $error("measurement state left over while unarmed");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && w_res && w_last |=> r_phase == otc_pkg::PH_IDLE && r_out_vld)
        else $error("final fine report did not end calibration");

    a_fstep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fstep <= otc_pkg::FINE_LAST_STEP)
        else $error("fine step out of range");

endmodule

/* rtl/oscillator_trim_calibrator_unit.sv */
// path: a transaction passes the input register, then the single update stage
// into the result register; a stalled result can hold it in the input register
// throughput: one transaction per cycle while the result side does not stall; the trim state is updated in every cycle
// that takes a transaction, and a divide by ten is one reciprocal multiply there
// a stalled result holds the input register, which then stalls the input side
// reset (synchronous, active low) sets calibration idle, clears both stages
// and loads the configuration registers with their default values
module oscillator_trim_calibrator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [15:0]        i_period_count,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_stage,
    output logic [7:0]         o_trim_used,
    output logic signed [16:0] o_avg_error,
    output logic [7:0]         o_best_trim,
    output logic               o_last
);

    otc_pkg::t_cfg  w_cfg;
    otc_pkg::t_item w_item;
    logic           w_in_vld;
    logic           w_take;

    otc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    otc_in_reg u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_op           (i_op),
        .i_period_count (i_period_count),
        .o_stall        (o_stall),
        .i_take         (w_take),
        .o_vld          (w_in_vld),
        .o_item         (w_item)
    );

    otc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_vld       (w_in_vld),
        .i_item      (w_item),
        .o_take      (w_take),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_stage     (o_stage),
        .o_trim_used (o_trim_used),
        .o_avg_error (o_avg_error),
        .o_best_trim (o_best_trim),
        .o_last      (o_last)
    );

endmodule

/* tb/sv/trim_report_checker.sv */
`timescale 1ns / 1ps

module trim_report_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_op,
    input  logic [15:0]       i_period_count,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_stage,
    input  logic [7:0]        i_trim_used,
    input  logic signed [16:0] i_avg_error,
    input  logic [7:0]        i_best_trim,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_scans_done,
    output int                o_coarse_reports,
    output int                o_fine_reports
);

    localparam logic [7:0] SWEEP_FIRST  = 8'hEF;
    localparam logic [7:0] SWEEP_END    = 8'h0F;
    localparam logic [7:0] FINE_BACKOFF = 8'd10;
    localparam logic [4:0] FINE_FINAL   = 5'd30;
    localparam logic [3:0] COARSE_SKIP  = 4'd1;
    localparam logic [3:0] COARSE_EDGES = 4'd2;
    localparam logic [3:0] FINE_SKIP    = 4'd5;
    localparam logic [3:0] FINE_EDGES   = 4'd15;
    localparam logic [2:0] NEAR_CAP     = 3'd7;
    localparam int         FINE_SAMPLES = 10;
    localparam int         SUM_HI       = 524287;
    localparam int         SUM_LO       = -524288;
    localparam int         AVG_HI       = 65535;
    localparam int         AVG_LO       = -65536;

    typedef struct packed {
        logic        stage;
        logic [7:0]  trim_used;
        logic [16:0] avg_error;
        logic [7:0]  best_trim;
        logic        last;
    } t_trim_report;

    logic [7:0]  cfg_default_trim;
    logic [15:0] cfg_ref_period;
    logic [15:0] cfg_keep_limit;
    logic [15:0] cfg_near_limit;
    logic [2:0]  cfg_run_needed;

    logic [1:0]  phase;
    logic [7:0]  trim_now;
    logic [7:0]  working_trim;
    logic [2:0]  near_run;
    logic        armed;
    logic [3:0]  edge_cnt;
    int          total_err;
    logic [4:0]  fine_step;

    t_trim_report pending_reports[$];
    int mismatches = 0;
    int scans_finished = 0;
    int coarse_seen = 0;
    int fine_seen = 0;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic advance_calibration(input logic op, input logic [15:0] ticks);
        t_trim_report rpt;
        logic [3:0]   skip;
        logic [3:0]   needed;
        logic         fine;
        int           err;
        if (op == otc_pkg::OP_START) begin
            phase = otc_pkg::PH_COARSE;
            working_trim = cfg_default_trim;
            trim_now = SWEEP_FIRST;
            near_run = '0;
            fine_step = '0;
            armed = 1'b0;
            edge_cnt = '0;
            total_err = 0;
            return;
        end
        // unused phase code behaves like idle
        if (phase != otc_pkg::PH_COARSE && phase != otc_pkg::PH_FINE) return;
        fine = (phase == otc_pkg::PH_FINE);
        if (!armed) begin
            armed = 1'b1;
            return;
        end
        skip = fine ? FINE_SKIP : COARSE_SKIP;
        needed = fine ? FINE_EDGES : COARSE_EDGES;
        if (edge_cnt >= skip)
            total_err = clamp(total_err + (int'(ticks) - int'(cfg_ref_period)), SUM_LO, SUM_HI);
        edge_cnt = edge_cnt + 4'd1;
        if (edge_cnt < needed) return;

        if (fine)
            err = clamp(total_err / FINE_SAMPLES, AVG_LO, AVG_HI);
        else
            err = clamp(total_err < 0 ? -total_err : total_err, AVG_LO, AVG_HI);
        armed = 1'b0;
        edge_cnt = '0;
        total_err = 0;

        rpt.stage = fine;
        rpt.trim_used = trim_now;
        rpt.avg_error = err[16:0];
        rpt.last = 1'b0;
        if (!fine) begin
            if (err < int'(cfg_keep_limit)) working_trim = trim_now;
            if (err < int'(cfg_near_limit)) begin
                if (near_run != NEAR_CAP) near_run = near_run + 3'd1;
            end else begin
                near_run = '0;
            end
            if (near_run == cfg_run_needed || trim_now < SWEEP_END) begin
                phase = otc_pkg::PH_FINE;
                fine_step = '0;
                trim_now = working_trim - FINE_BACKOFF;
            end else begin
                trim_now = trim_now - 8'd1;
            end
        end else if (fine_step >= FINE_FINAL) begin
            rpt.last = 1'b1;
            phase = otc_pkg::PH_IDLE;
            fine_step = '0;
            scans_finished++;
        end else begin
            fine_step = fine_step + 5'd1;
            trim_now = working_trim + {3'b000, fine_step} - FINE_BACKOFF;
        end
        rpt.best_trim = working_trim;
        pending_reports.push_back(rpt);
    endtask

    task automatic check_field(input string name, input integer want, input integer got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_trim_report want;
        if (!i_rst_n) begin
            cfg_default_trim = 8'd128;
            cfg_ref_period = 16'd32768;
            cfg_keep_limit = 16'd200;
            cfg_near_limit = 16'd1000;
            cfg_run_needed = 3'd5;
            phase = otc_pkg::PH_IDLE;
            trim_now = '0;
            working_trim = '0;
            near_run = '0;
            armed = 1'b0;
            edge_cnt = '0;
            total_err = 0;
            fine_step = '0;
            pending_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    otc_pkg::REG_DEFAULT_TRIM: cfg_default_trim = i_cfg_data[7:0];
                    otc_pkg::REG_REF_PERIOD:   cfg_ref_period = i_cfg_data;
                    otc_pkg::REG_KEEP_LIMIT:   cfg_keep_limit = i_cfg_data;
                    otc_pkg::REG_NEAR_LIMIT:   cfg_near_limit = i_cfg_data;
                    otc_pkg::REG_RUN_NEEDED:   cfg_run_needed = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                advance_calibration(i_op, i_period_count);
            if (i_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("report with no transaction behind it: stage %0d trim_used %0d",
                           i_stage, i_trim_used);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("stage", want.stage, i_stage);
                    check_field("trim_used", want.trim_used, i_trim_used);
                    check_field("avg_error", $signed(want.avg_error), i_avg_error);
                    check_field("best_trim", want.best_trim, i_best_trim);
                    check_field("last", want.last, i_last);
                    if (want.stage) fine_seen++;
                    else coarse_seen++;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending <= pending_reports.size();
        o_scans_done <= scans_finished;
        o_coarse_reports <= coarse_seen;
        o_fine_reports <= fine_seen;
    end

endmodule

/* tb/sv/oscillator_trim_calibrator_unit_test.sv */
`timescale 1ns / 1ps

module oscillator_trim_calibrator_unit_test;

    localparam int WATCHDOG_LIMIT = 1000;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_op = otc_pkg::OP_EDGE;
    logic [15:0]        i_period_count = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_stage;
    logic [7:0]         o_trim_used;
    logic signed [16:0] o_avg_error;
    logic [7:0]         o_best_trim;
    logic               o_last;

    int fail_count;
    int pending;
    int scans_done;
    int coarse_reports;
    int fine_reports;

    int gap_pct = 20;
    int stall_pct = 20;
    int items_sent = 0;
    int quiet_cycles = 0;
    logic [15:0] ref_now = 16'd32768;

    oscillator_trim_calibrator_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_period_count (i_period_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_stage        (o_stage),
        .o_trim_used    (o_trim_used),
        .o_avg_error    (o_avg_error),
        .o_best_trim    (o_best_trim),
        .o_last         (o_last)
    );

    trim_report_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_op             (i_op),
        .i_period_count   (i_period_count),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_stage          (o_stage),
        .i_trim_used      (o_trim_used),
        .i_avg_error      (o_avg_error),
        .i_best_trim      (o_best_trim),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_scans_done     (scans_done),
        .o_coarse_reports (coarse_reports),
        .o_fine_reports   (fine_reports)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d reports outstanding",
                     quiet_cycles, pending);
            $display("[oscillator_trim_calibrator_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic op, input logic [15:0] count);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_period_count <= count;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // arming edge, warm-up edge, then the sampled edge of one coarse step
    task automatic measure(input logic [15:0] arm_ticks, input logic [15:0] warm_ticks,
                           input logic [15:0] sample_ticks);
        send(otc_pkg::OP_EDGE, arm_ticks);
        send(otc_pkg::OP_EDGE, warm_ticks);
        send(otc_pkg::OP_EDGE, sample_ticks);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic configure(input logic [7:0] trim0, input logic [15:0] ref_ticks,
                             input logic [15:0] keep, input logic [15:0] near,
                             input logic [2:0] run_len);
        write_reg(otc_pkg::REG_DEFAULT_TRIM, {8'($urandom), trim0});
        write_reg(otc_pkg::REG_REF_PERIOD, ref_ticks);
        write_reg(otc_pkg::REG_KEEP_LIMIT, keep);
        write_reg(otc_pkg::REG_NEAR_LIMIT, near);
        write_reg(otc_pkg::REG_RUN_NEEDED, {13'($urandom), run_len});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ref_now = ref_ticks;
    endtask

    function automatic logic [15:0] pick_period(input int near_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < near_pct)
            return ref_now + 16'($urandom_range(0, 2400)) - 16'd1200;
        if (roll < near_pct + 6)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // start, then reference edges until a scan completes or the edge budget runs out
    task automatic run_calibration(input int max_edges, input int near_pct,
                                   input int restart_permille);
        int base;
        int n;
        base = scans_done;
        send(otc_pkg::OP_START, 16'($urandom));
        n = 0;
        while (scans_done == base && n < max_edges) begin
            if ($urandom_range(0, 999) < restart_permille)
                send(otc_pkg::OP_START, 16'($urandom));
            else
                send(otc_pkg::OP_EDGE, pick_period(near_pct));
            n++;
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: edges while idle, period extremes, keep and near edges
        send(otc_pkg::OP_EDGE, 16'hFFFF);
        send(otc_pkg::OP_EDGE, 16'h0000);
        send(otc_pkg::OP_START, 16'hFFFF);
        measure(16'h1234, 16'hFFFF, 16'h0000);
        measure(16'h0000, 16'h0000, 16'hFFFF);
        measure(16'hFFFF, 16'h8000, 16'h8000);
        send(otc_pkg::OP_EDGE, 16'h0000);
        send(otc_pkg::OP_START, 16'h0000);
        measure(16'h0001, 16'h7FFF, 16'h8000 + 16'd199);
        measure(16'h8000, 16'h8000, 16'h8000 - 16'd200);
        measure(16'hFFFE, 16'h0000, 16'h8000 + 16'd1000);
        run_calibration(40, 75, 0);
        settle();

        // zero reference and wide limits: sums saturate high, run of seven ends the sweep
        configure(8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 3'd7);
        run_calibration(60, 60, 0);
        settle();

        // nothing kept, near run of zero matches at once, a whole fine scan wraps past 255
        configure(8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 3'd0);
        run_calibration(520, 30, 0);
        settle();

        // near run saturates and never matches zero, so the sweep keeps going
        gap_pct = 0;
        stall_pct = 0;
        configure(8'($urandom), 16'($urandom_range(1000, 64000)),
                  16'($urandom_range(0, 1500)), 16'hFFFF, 3'd0);
        run_calibration(160, 80, 0);
        settle();

        gap_pct = 20;
        stall_pct = 20;
        repeat (2) begin
            configure(8'($urandom), 16'($urandom), 16'($urandom_range(0, 1500)),
                      16'($urandom_range(200, 3000)), 3'($urandom_range(1, 7)));
            run_calibration(80, 85, 4);
            settle();
        end

        $display("sent %0d transactions over six register settings", items_sent);
        $display("checked %0d coarse and %0d fine reports, %0d complete scans",
                 coarse_reports, fine_reports, scans_done);
        if (fail_count == 0)
            $display("[oscillator_trim_calibrator_unit] OK");
        else
            $display("[oscillator_trim_calibrator_unit] ERROR");
        $finish;
    end

endmodule
